// ===== rtl/h2dw_pkg.sv =====
`default_nettype none
package h2dw_pkg;

    localparam int SAMPLE_W  = 20;
    localparam int MAX_COLS  = 1024;
    localparam int MAX_ROWS  = 1024;
    localparam int COL_W     = $clog2(MAX_COLS);
    localparam int ROW_W     = $clog2(MAX_ROWS);
    localparam int SIZE_W    = 11;
    localparam int POS_W     = 10;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 11;

    localparam logic [CFG_IDX_W-1:0] REG_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS = 2'd2;

    localparam logic MODE_FWD = 1'b0;
    localparam logic MODE_INV = 1'b1;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic [POS_W-1:0]           t_pos;

endpackage
`default_nettype wire

// ===== rtl/h2dw_if.sv =====
`default_nettype none
interface h2dw_in_if;
    logic                valid;
    logic                ready;
    h2dw_pkg::t_sample   sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface h2dw_out_if;
    logic                valid;
    logic                ready;
    h2dw_pkg::t_sample   value;
    h2dw_pkg::t_pos      out_row;
    h2dw_pkg::t_pos      out_col;
    logic [1:0]          subband;
    logic                last_of_group;
    logic                last_of_image;

    modport source (output valid, output value, output out_row, output out_col,
                    output subband, output last_of_group, output last_of_image,
                    input ready);
    modport sink   (input valid, input value, input out_row, input out_col,
                    input subband, input last_of_group, input last_of_image,
                    output ready);
endinterface

interface h2dw_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [h2dw_pkg::CFG_IDX_W-1:0]     index;
    logic [h2dw_pkg::CFG_DAT_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/h2dw_ram.sv =====
`default_nettype none
module h2dw_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/haar_2d_wavelet_one_level_top.sv =====
`default_nettype none
// channel   dir   payload                                           transfer
// i_cfg     in    index[1:0], data[10:0]                            valid && ready
// i_in      in    sample[19:0] signed Q15.4                         valid && ready
// o_out     out   value, out_row, out_col, subband, last flags      valid && ready
//
// Even rows: one sample per cycle, written straight into the line store; the first one
// may wait while the last odd-row group is held. Odd rows: a 2x2 group every two samples
// gives four results, one per cycle while o_out is ready, and the single group buffer
// holds odd-row input until all four are taken. A group goes via stage 1 to that buffer.
// Reset is synchronous; the line store is not cleared. Configuration is always ready.
module haar_2d_wavelet_one_level_top (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    h2dw_cfg_if.sink    i_cfg,
    h2dw_in_if.sink     i_in,
    h2dw_out_if.source  o_out
);

    localparam int SW = h2dw_pkg::SAMPLE_W;
    localparam int XW = h2dw_pkg::SAMPLE_W + 2;
    localparam int HC = h2dw_pkg::COL_W - 1;
    localparam int HR = h2dw_pkg::ROW_W - 1;

    function automatic h2dw_pkg::t_sample half_sat(input logic signed [XW-1:0] s);
        logic signed [XW-1:0] h;
        h = s[XW-1] ? (s >>> 1) : ((s + XW'(1)) >>> 1);
        if (h > XW'(signed'(524287))) begin
            h = XW'(signed'(524287));
        end else if (h < -XW'(signed'(524288))) begin
            h = -XW'(signed'(524288));
        end
        return h[SW-1:0];
    endfunction

    function automatic logic [h2dw_pkg::SIZE_W-1:0] eff_size(
        input logic [h2dw_pkg::SIZE_W-1:0] r, input logic [h2dw_pkg::SIZE_W-1:0] m);
        logic [h2dw_pkg::SIZE_W-1:0] s;
        s = {r[h2dw_pkg::SIZE_W-1:1], 1'b0};
        if (s < h2dw_pkg::SIZE_W'(2)) begin
            s = h2dw_pkg::SIZE_W'(2);
        end
        if (s > m) begin
            s = m;
        end
        return s;
    endfunction

    logic                              r_mode;
    logic [h2dw_pkg::SIZE_W-1:0]       r_cols_reg, r_rows_reg;
    logic [h2dw_pkg::SIZE_W-1:0]       cols_eff, rows_eff;
    logic [h2dw_pkg::COL_W-1:0]        r_col;
    logic [h2dw_pkg::ROW_W-1:0]        r_row;
    logic [h2dw_pkg::SIZE_W-1:0]       n_col_inc, n_row_inc;

    logic                              in_rdy, in_acc;
    h2dw_pkg::t_sample                 ram_rdata;

    logic                              r_s1_vld, r_s1_odd_row, r_s1_odd_col, r_s1_last;
    h2dw_pkg::t_sample                 r_s1_x;
    logic [HR-1:0]                     r_s1_i;
    logic [HC-1:0]                     r_s1_j;
    logic                              s1_grp, s1_fire, grp_free;

    h2dw_pkg::t_sample                 r_a, r_c;
    logic signed [XW-1:0]              ea, eb, ec, ed;

    logic                              r_g_vld, r_g_mode, r_g_last;
    logic [1:0]                        r_k;
    h2dw_pkg::t_sample                 r_gv [4];
    logic [HR-1:0]                     r_g_i;
    logic [HC-1:0]                     r_g_j;
    logic                              out_acc;

    assign cols_eff = eff_size(r_cols_reg, h2dw_pkg::SIZE_W'(h2dw_pkg::MAX_COLS));
    assign rows_eff = eff_size(r_rows_reg, h2dw_pkg::SIZE_W'(h2dw_pkg::MAX_ROWS));

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= h2dw_pkg::MODE_FWD;
            r_cols_reg <= h2dw_pkg::SIZE_W'(1024);
            r_rows_reg <= h2dw_pkg::SIZE_W'(1024);
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                h2dw_pkg::REG_MODE: r_mode     <= i_cfg.data[0];
                h2dw_pkg::REG_COLS: r_cols_reg <= i_cfg.data;
                h2dw_pkg::REG_ROWS: r_rows_reg <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // raster position of the next sample
    assign n_col_inc = h2dw_pkg::SIZE_W'(r_col) + h2dw_pkg::SIZE_W'(1);
    assign n_row_inc = h2dw_pkg::SIZE_W'(r_row) + h2dw_pkg::SIZE_W'(1);

    assign in_acc     = i_in.valid && in_rdy;
    assign i_in.ready = in_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_acc) begin
            if (n_col_inc >= cols_eff) begin
                r_col <= '0;
                r_row <= (n_row_inc >= rows_eff) ? '0 : n_row_inc[h2dw_pkg::ROW_W-1:0];
            end else begin
                r_col <= n_col_inc[h2dw_pkg::COL_W-1:0];
            end
        end
    end

    h2dw_ram #(
        .WIDTH (SW),
        .DEPTH (h2dw_pkg::MAX_COLS)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (in_acc && !r_row[0]),
        .i_waddr (r_col),
        .i_wdata (i_in.sample),
        .i_re    (in_acc && r_row[0]),
        .i_raddr (r_col),
        .o_rdata (ram_rdata)
    );

    // stage 1: store data arrives
    assign s1_grp   = r_s1_odd_row && r_s1_odd_col;
    assign grp_free = !r_g_vld || (o_out.ready && (r_k == 2'd3));
    assign s1_fire  = r_s1_vld && (!s1_grp || grp_free);
    assign in_rdy   = !r_s1_vld || s1_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (in_rdy) begin
            r_s1_vld <= in_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_x       <= i_in.sample;
            r_s1_odd_row <= r_row[0];
            r_s1_odd_col <= r_col[0];
            r_s1_i       <= r_row[h2dw_pkg::ROW_W-1:1];
            r_s1_j       <= r_col[h2dw_pkg::COL_W-1:1];
            r_s1_last    <= (n_row_inc >= rows_eff) && (n_col_inc >= cols_eff);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c <= '0;
        end else if (s1_fire && r_s1_odd_row && !r_s1_odd_col) begin
            r_c <= r_s1_x;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && r_s1_odd_row && !r_s1_odd_col) begin
            r_a <= ram_rdata;
        end
    end

    assign ea = XW'(r_a);
    assign eb = XW'(ram_rdata);
    assign ec = XW'(r_c);
    assign ed = XW'(r_s1_x);

    // group buffer and result sequencing
    assign out_acc = r_g_vld && o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_vld <= 1'b0;
            r_k     <= '0;
        end else if (s1_fire && s1_grp) begin
            r_g_vld <= 1'b1;
            r_k     <= '0;
        end else if (out_acc) begin
            r_k <= r_k + 2'd1;
            if (r_k == 2'd3) begin
                r_g_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && s1_grp) begin
            r_gv[0]  <= half_sat(ea + eb + ec + ed);
            r_gv[1]  <= half_sat(ea - eb + ec - ed);
            r_gv[2]  <= half_sat(ea + eb - ec - ed);
            r_gv[3]  <= half_sat(ea - eb - ec + ed);
            r_g_i    <= r_s1_i;
            r_g_j    <= r_s1_j;
            r_g_mode <= r_mode;
            r_g_last <= r_s1_last;
        end
    end

    assign o_out.valid         = r_g_vld;
    assign o_out.value         = r_gv[r_k];
    assign o_out.subband       = r_k;
    assign o_out.last_of_group = (r_k == 2'd3);
    assign o_out.last_of_image = (r_k == 2'd3) && r_g_last;

    always_comb begin
        if (r_g_mode == h2dw_pkg::MODE_INV) begin
            o_out.out_row = h2dw_pkg::POS_W'({r_g_i, r_k[1]});
            o_out.out_col = h2dw_pkg::POS_W'({r_g_j, r_k[0]});
        end else begin
            o_out.out_row = h2dw_pkg::POS_W'(h2dw_pkg::SIZE_W'(r_g_i)
                          + (r_k[1] ? (rows_eff >> 1) : h2dw_pkg::SIZE_W'(0)));
            o_out.out_col = h2dw_pkg::POS_W'(h2dw_pkg::SIZE_W'(r_g_j)
                          + (r_k[0] ? (cols_eff >> 1) : h2dw_pkg::SIZE_W'(0)));
        end
    end

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
module tb_top;

    typedef h2dw_pkg::t_sample t_sample;
    typedef h2dw_pkg::t_pos    t_pos;

    localparam int IDLE_PCT      = 34;
    localparam int STALL_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_ITEMS  = 110;
    localparam int QUIET_ITEMS   = 48;
    localparam t_sample S_MAX    = t_sample'(20'h7FFFF);
    localparam t_sample S_MIN    = t_sample'(20'h80000);

    typedef struct {
        t_sample    value;
        t_pos       row;
        t_pos       col;
        logic [1:0] band;
        logic       grp_end;
        logic       img_end;
    } t_haar_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    h2dw_in_if  in_if ();
    h2dw_out_if out_if ();
    h2dw_cfg_if cfg_if ();

    haar_2d_wavelet_one_level_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_sample                     line_store [h2dw_pkg::MAX_COLS];
    t_sample                     held_odd;
    int unsigned                 col_pos;
    int unsigned                 row_pos;
    logic                        cur_mode;
    logic [h2dw_pkg::SIZE_W-1:0] cols_reg;
    logic [h2dw_pkg::SIZE_W-1:0] rows_reg;
    t_haar_result                pending_results [$];
    t_haar_result                want;

    bit quiet = 1'b0;
    int errors = 0;
    int items_sent = 0;
    int results_seen = 0;
    int images_sent = 0;
    int stall_cycles = 0;

    function automatic int unsigned clamp_size(logic [h2dw_pkg::SIZE_W-1:0] r,
                                               int unsigned lim);
        int unsigned s;
        s = {r[h2dw_pkg::SIZE_W-1:1], 1'b0};
        if (s < 2) s = 2;
        if (s > lim) s = lim;
        return s;
    endfunction

    function automatic t_sample round_half(longint s);
        longint h;
        h = (s >= 0) ? (s + 1) / 2 : (s - 1) / 2;
        if (h > longint'(S_MAX)) h = longint'(S_MAX);
        if (h < longint'(S_MIN)) h = longint'(S_MIN);
        return t_sample'(h);
    endfunction

    task automatic predict_sample(t_sample x);
        int unsigned cols;
        int unsigned rows;
        int unsigned i;
        int unsigned j;
        longint a;
        longint b;
        longint c;
        longint d;
        longint sums [4];
        t_haar_result r;
        cols = clamp_size(cols_reg, h2dw_pkg::MAX_COLS);
        rows = clamp_size(rows_reg, h2dw_pkg::MAX_ROWS);
        if (row_pos % 2 == 0) begin
            line_store[col_pos] = x;
        end else if (col_pos % 2 == 0) begin
            held_odd = x;
        end else begin
            a = longint'(line_store[col_pos - 1]);
            b = longint'(line_store[col_pos]);
            c = longint'(held_odd);
            d = longint'(x);
            sums[0] = a + b + c + d;
            sums[1] = a - b + c - d;
            sums[2] = a + b - c - d;
            sums[3] = a - b - c + d;
            i = row_pos / 2;
            j = col_pos / 2;
            for (int k = 0; k < 4; k++) begin
                r.value = round_half(sums[k]);
                if (cur_mode == h2dw_pkg::MODE_FWD) begin
                    r.row = t_pos'(i + (((k & 2) != 0) ? rows / 2 : 0));
                    r.col = t_pos'(j + (((k & 1) != 0) ? cols / 2 : 0));
                end else begin
                    r.row = t_pos'(2 * i + (k >> 1));
                    r.col = t_pos'(2 * j + (k & 1));
                end
                r.band    = 2'(k);
                r.grp_end = (k == 3);
                r.img_end = (k == 3) && (row_pos + 1 >= rows) && (col_pos + 1 >= cols);
                pending_results.push_back(r);
            end
        end
        col_pos++;
        if (col_pos >= cols) begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= rows) row_pos = 0;
        end
    endtask

    function automatic t_sample rand_sample();
        case ($urandom_range(0, 9))
            0: return S_MAX;
            1: return S_MIN;
            2, 3, 4: return t_sample'(int'($urandom_range(0, 64)) - 32);
            default: return t_sample'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(string msg);
        errors++;
        $display("tb: mismatch at %0t: %s", $realtime, msg);
    endtask

    task automatic send_sample(t_sample s);
        while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid  <= 1'b1;
        in_if.sample <= s;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        predict_sample(s);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        in_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [h2dw_pkg::CFG_IDX_W-1:0] idx,
                             logic [h2dw_pkg::CFG_DAT_W-1:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        case (idx)
            h2dw_pkg::REG_MODE: cur_mode = val[0];
            h2dw_pkg::REG_COLS: cols_reg = val;
            h2dw_pkg::REG_ROWS: rows_reg = val;
            default: ;
        endcase
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic setup_image(logic m, logic [h2dw_pkg::CFG_DAT_W-1:0] c,
                               logic [h2dw_pkg::CFG_DAT_W-1:0] r);
        wait_drained();
        write_reg(h2dw_pkg::REG_MODE, h2dw_pkg::CFG_DAT_W'(m));
        write_reg(h2dw_pkg::REG_COLS, c);
        write_reg(h2dw_pkg::REG_ROWS, r);
        images_sent++;
    endtask

    // pause_at < 0: no mid-image hold-off
    task automatic send_image(int pause_at);
        int total;
        total = clamp_size(cols_reg, h2dw_pkg::MAX_COLS) *
                clamp_size(rows_reg, h2dw_pkg::MAX_ROWS);
        for (int n = 0; n < total; n++) begin
            if (n == pause_at) wait_drained();
            send_sample(rand_sample());
        end
    endtask

    task automatic test_directed_corners();
        t_sample pix [16];
        pix = '{S_MAX, S_MAX, S_MIN, S_MIN,
                S_MAX, S_MAX, S_MIN, S_MIN,
                t_sample'(1), t_sample'(0), S_MAX, S_MIN,
                t_sample'(0), t_sample'(0), S_MIN, S_MAX};
        setup_image(h2dw_pkg::MODE_FWD, 11'd4, 11'd4);
        foreach (pix[n]) send_sample(pix[n]);
    endtask

    task automatic test_inverse_groups();
        t_sample coef [8];
        coef = '{t_sample'(10), t_sample'(-3), S_MAX, S_MIN,
                 t_sample'(7), t_sample'(-1), S_MAX, S_MAX};
        setup_image(h2dw_pkg::MODE_INV, 11'd4, 11'd2);
        foreach (coef[n]) send_sample(coef[n]);
    endtask

    task automatic test_size_limits();
        setup_image(h2dw_pkg::MODE_INV, 11'd0, 11'd1);
        send_image(-1);
        setup_image(h2dw_pkg::MODE_FWD, 11'd5, 11'd3);
        send_image(-1);
        // cut a full-height image short, then shrink the height so the count wraps
        setup_image(h2dw_pkg::MODE_FWD, 11'd2, 11'd2047);
        quiet = 1'b1;
        repeat (QUIET_ITEMS) send_sample(rand_sample());
        wait_drained();
        quiet = 1'b0;
        write_reg(h2dw_pkg::REG_ROWS, 11'd2);
        repeat (2) send_sample(rand_sample());
    endtask

    // shrink the width while the column count is already past it, flip mode mid-image
    task automatic test_shrink_mid_image();
        setup_image(h2dw_pkg::MODE_FWD, 11'd8, 11'd4);
        repeat (7) send_sample(rand_sample());
        wait_drained();
        write_reg(h2dw_pkg::REG_COLS, 11'd4);
        write_reg(h2dw_pkg::REG_MODE, h2dw_pkg::CFG_DAT_W'(h2dw_pkg::MODE_INV));
        repeat (5) send_sample(rand_sample());
        wait_drained();
        write_reg(h2dw_pkg::REG_MODE, h2dw_pkg::CFG_DAT_W'(h2dw_pkg::MODE_FWD));
        repeat (8) send_sample(rand_sample());
    endtask

    task automatic test_random_images();
        int start;
        int img;
        logic [h2dw_pkg::CFG_DAT_W-1:0] c;
        logic [h2dw_pkg::CFG_DAT_W-1:0] r;
        start = items_sent;
        img = 0;
        while (items_sent - start < RANDOM_ITEMS) begin
            c = ($urandom_range(0, 9) == 0) ? h2dw_pkg::CFG_DAT_W'($urandom_range(10, 20))
                                            : h2dw_pkg::CFG_DAT_W'($urandom_range(2, 9));
            r = h2dw_pkg::CFG_DAT_W'($urandom_range(2, 6));
            setup_image(logic'($urandom_range(0, 1)), c, r);
            send_image((img == 2) ? int'(clamp_size(c, h2dw_pkg::MAX_COLS) + 3) : -1);
            img++;
        end
    endtask

    always @(negedge i_clk) begin
        out_if.ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result with nothing pending, value %0d",
                                          out_if.value));
            end else begin
                want = pending_results.pop_front();
                if (out_if.value !== want.value)
                    report_mismatch($sformatf("value got %0d want %0d",
                                              out_if.value, want.value));
                if (out_if.out_row !== want.row)
                    report_mismatch($sformatf("out_row got %0d want %0d",
                                              out_if.out_row, want.row));
                if (out_if.out_col !== want.col)
                    report_mismatch($sformatf("out_col got %0d want %0d",
                                              out_if.out_col, want.col));
                if (out_if.subband !== want.band)
                    report_mismatch($sformatf("subband got %0d want %0d",
                                              out_if.subband, want.band));
                if (out_if.last_of_group !== want.grp_end)
                    report_mismatch($sformatf("last_of_group got %b want %b",
                                              out_if.last_of_group, want.grp_end));
                if (out_if.last_of_image !== want.img_end)
                    report_mismatch($sformatf("last_of_image got %b want %b",
                                              out_if.last_of_image, want.img_end));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
            (cfg_if.valid && cfg_if.ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("tb: stalled with %0d results pending", pending_results.size());
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        in_if.valid   = 1'b0;
        in_if.sample  = '0;
        cfg_if.valid  = 1'b0;
        cfg_if.index  = '0;
        cfg_if.data   = '0;
        out_if.ready  = 1'b0;
        cur_mode      = h2dw_pkg::MODE_FWD;
        cols_reg      = h2dw_pkg::SIZE_W'(h2dw_pkg::MAX_COLS);
        rows_reg      = h2dw_pkg::SIZE_W'(h2dw_pkg::MAX_ROWS);
        held_odd      = '0;
        col_pos       = 0;
        row_pos       = 0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed_corners();
        test_inverse_groups();
        test_size_limits();
        test_shrink_mid_image();
        test_random_images();

        wait_drained();
        repeat (20) @(negedge i_clk);
        $display("tb: %0d samples over %0d images, %0d results checked, %0d mismatches",
                 items_sent, images_sent, results_seen, errors);
        $display("tb: covered forward and inverse, saturation, rounding, clamped sizes");
        $display("tb: and size and mode changes part way through an image");
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/h2dw_pkg.sv
rtl/h2dw_if.sv
rtl/h2dw_ram.sv
rtl/haar_2d_wavelet_one_level_top.sv
tb/tb_top.sv
